// File: rtl/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants of the clipped-border box filter.
// ----------------------------------------------------------------------------
package bfe_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 13;
  localparam int CHAN_W    = 3;
  localparam int RADIUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = 2'd3;

  // input word kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

// File: rtl/bfe_in_if.sv
// ----------------------------------------------------------------------------
// bfe_in_if
// Pixel input channel: valid/ready with req_type and four samples.
// ----------------------------------------------------------------------------
interface bfe_in_if
  import bfe_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    req_type;
  sample_t sample_a;
  sample_t sample_b;
  sample_t sample_c;
  sample_t sample_d;

  modport source (output valid, req_type, sample_a, sample_b, sample_c, sample_d,
                  input ready);
  modport sink   (input valid, req_type, sample_a, sample_b, sample_c, sample_d,
                  output ready);
endinterface

// File: rtl/bfe_out_if.sv
// ----------------------------------------------------------------------------
// bfe_out_if
// Result channel: valid/ready with four window means and a frame marker.
// ----------------------------------------------------------------------------
interface bfe_out_if
  import bfe_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t mean_a;
  sample_t mean_b;
  sample_t mean_c;
  sample_t mean_d;
  logic    last_of_frame;

  modport source (output valid, mean_a, mean_b, mean_c, mean_d, last_of_frame,
                  input ready);
  modport sink   (input valid, mean_a, mean_b, mean_c, mean_d, last_of_frame,
                  output ready);
endinterface

// File: rtl/bfe_cfg_if.sv
// ----------------------------------------------------------------------------
// bfe_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface bfe_cfg_if
  import bfe_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/box_filter_edge_normalized.sv
// ----------------------------------------------------------------------------
// box_filter_edge_normalized
// Streaming box filter, window clipped to the frame, up to four channels.
// ----------------------------------------------------------------------------
// Pixels go into a line store ring of 2*R*W+2*R+1 words (one write port and
// one read port), with R and W the maximum radius and width. An accepted word
// that produces no result only passes through the check state; a word that
// produces one also walks the window through the store, one read per window
// position, then runs a restoring divider over the sum width. The result
// sits in an output register and the next word is taken while it waits.
// Output for pixel p appears on the word that delivers pixel p+r*w+r; after
// the last pixel the host sends flush words until last_of_frame shows. A
// configuration write restarts the frame. No clearing pass is needed.
module box_filter_edge_normalized
  import bfe_pkg::*;
#(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_RADIUS   = 3,
  parameter int MAX_CHANNELS = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  bfe_in_if.sink    in_ch,
  bfe_out_if.source out_ch,
  bfe_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int NWIN  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CW    = $clog2(NWIN + 1);
  localparam int SW    = $clog2(NWIN * 255 + 1);
  localparam int IW    = $clog2(SW + 1);
  localparam int PW    = WIDTH_W + HEIGHT_W;
  localparam int XW    = WIDTH_W + 2;
  localparam int YW    = HEIGHT_W + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // configuration
  logic [WIDTH_W-1:0]  fw_r;
  logic [HEIGHT_W-1:0] fh_r;
  logic [CHAN_W-1:0]   fc_r;
  logic [RADIUS_W-1:0] fr_r;

  logic [2:0] state_r;

  // stream positions
  logic [WIDTH_W-1:0]  in_col_r, out_col_r;
  logic [HEIGHT_W-1:0] in_row_r, out_row_r;
  logic [PW-1:0]       in_cnt_r, out_cnt_r;
  logic [AW-1:0]       wptr_r, optr_r;

  // window walk
  logic signed [XW-1:0] wx_r;
  logic signed [YW-1:0] wy_r;
  logic [AW-1:0]        ra_r, ca_r;
  logic                 rd_en_r;
  logic [31:0]          rd_data_r;
  logic [SW-1:0]        sum_r [4];
  logic [CW-1:0]        cnt_r;

  // divider
  logic [SW-1:0] quo_r [4];
  logic [CW:0]   rem_r [4];
  logic [IW-1:0] dcnt_r;

  logic [31:0] mem [DEPTH];

  // effective settings
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [CHAN_W-1:0]   ch_eff;
  logic [RADIUS_W-1:0] r_eff;
  logic [PW-1:0]       total;
  logic [PW-1:0]       lag;
  logic                in_done;
  logic                produce;
  logic [AW:0]         start_addr;
  logic [AW:0]         row_next;
  logic                in_win;
  logic                in_acc, pix_acc, cfg_acc, out_load;
  logic [31:0]         packed_px;
  logic signed [XW-1:0] x_lo, x_hi;
  logic signed [YW-1:0] y_lo, y_hi;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_r;
    end
    h_eff = (fh_r == '0) ? HEIGHT_W'(1) :
            (fh_r > HEIGHT_W'(4096)) ? HEIGHT_W'(4096) : fh_r;
    if (fc_r == '0) begin
      ch_eff = CHAN_W'(1);
    end else if (32'(fc_r) > MAX_CHANNELS) begin
      ch_eff = CHAN_W'(MAX_CHANNELS);
    end else begin
      ch_eff = fc_r;
    end
    r_eff = (32'(fr_r) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : fr_r;
  end

  assign total   = PW'(w_eff) * PW'(h_eff);
  assign lag     = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
  assign in_done = in_row_r >= h_eff;
  assign produce = in_done || (out_cnt_r + lag < in_cnt_r);

  assign start_addr = ({1'b0, optr_r} >= (AW + 1)'(lag)) ?
                      {1'b0, optr_r} - (AW + 1)'(lag) :
                      {1'b0, optr_r} + (AW + 1)'(DEPTH) - (AW + 1)'(lag);

  always_comb begin
    row_next = {1'b0, ra_r} + (AW + 1)'(w_eff);
    if (row_next >= (AW + 1)'(DEPTH)) begin
      row_next = row_next - (AW + 1)'(DEPTH);
    end
  end

  assign x_lo = $signed({2'b0, out_col_r}) - $signed(XW'(r_eff));
  assign x_hi = $signed({2'b0, out_col_r}) + $signed(XW'(r_eff));
  assign y_lo = $signed({2'b0, out_row_r}) - $signed(YW'(r_eff));
  assign y_hi = $signed({2'b0, out_row_r}) + $signed(YW'(r_eff));

  assign in_win = (wx_r >= 0) && (wx_r < $signed({2'b0, w_eff})) &&
                  (wy_r >= 0) && (wy_r < $signed({2'b0, h_eff}));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign pix_acc  = in_acc && (in_ch.req_type == REQ_PIXEL) && !in_done;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_load = (state_r == S_OUT) && (!out_ch.valid || out_ch.ready);

  // inactive channels are stored as zero
  always_comb begin
    packed_px = '0;
    packed_px[7:0] = in_ch.sample_a;
    if (ch_eff > CHAN_W'(1)) packed_px[15:8]  = in_ch.sample_b;
    if (ch_eff > CHAN_W'(2)) packed_px[23:16] = in_ch.sample_c;
    if (ch_eff > CHAN_W'(3)) packed_px[31:24] = in_ch.sample_d;
  end

  // line store: written on pixel words, read during the window walk
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      mem[wptr_r] <= packed_px;
    end
    rd_data_r <= mem[ca_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= WIDTH_W'(640);
      fh_r <= HEIGHT_W'(480);
      fc_r <= CHAN_W'(3);
      fr_r <= RADIUS_W'(1);
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        REG_FRAME_WIDTH:   fw_r <= cfg_ch.data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT:  fh_r <= cfg_ch.data[HEIGHT_W-1:0];
        REG_CHANNEL_COUNT: fc_r <= cfg_ch.data[CHAN_W-1:0];
        REG_KERNEL_RADIUS: fr_r <= cfg_ch.data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // control, positions and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      in_col_r      <= '0;
      in_row_r      <= '0;
      in_cnt_r      <= '0;
      wptr_r        <= '0;
      out_col_r     <= '0;
      out_row_r     <= '0;
      out_cnt_r     <= '0;
      optr_r        <= '0;
      rd_en_r       <= 1'b0;
      out_ch.valid  <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (pix_acc) begin
              wptr_r   <= (wptr_r == LAST_ADDR) ? '0 : wptr_r + 1'b1;
              in_cnt_r <= in_cnt_r + 1'b1;
              if (in_col_r + 1'b1 >= w_eff) begin
                in_col_r <= '0;
                in_row_r <= in_row_r + 1'b1;
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
            end
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (produce) begin
            wx_r    <= x_lo;
            wy_r    <= y_lo;
            ra_r    <= start_addr[AW-1:0];
            ca_r    <= start_addr[AW-1:0];
            state_r <= S_SCAN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SCAN: begin
          rd_en_r <= in_win;
          if (wx_r == x_hi) begin
            if (wy_r == y_hi) begin
              state_r <= S_DRAIN;
            end else begin
              wy_r <= wy_r + 1'b1;
              wx_r <= x_lo;
              ra_r <= row_next[AW-1:0];
              ca_r <= row_next[AW-1:0];
            end
          end else begin
            wx_r <= wx_r + 1'b1;
            ca_r <= (ca_r == LAST_ADDR) ? '0 : ca_r + 1'b1;
          end
        end
        S_DRAIN: begin
          rd_en_r <= 1'b0;
          state_r <= S_DINIT;
        end
        S_DINIT: begin
          for (int k = 0; k < 4; k++) begin
            quo_r[k] <= sum_r[k];
            rem_r[k] <= '0;
          end
          dcnt_r  <= IW'(SW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          for (int k = 0; k < 4; k++) begin
            if ({rem_r[k][CW-1:0], quo_r[k][SW-1]} >= {1'b0, cnt_r}) begin
              rem_r[k] <= {rem_r[k][CW-1:0], quo_r[k][SW-1]} - {1'b0, cnt_r};
              quo_r[k] <= {quo_r[k][SW-2:0], 1'b1};
            end else begin
              rem_r[k] <= {rem_r[k][CW-1:0], quo_r[k][SW-1]};
              quo_r[k] <= {quo_r[k][SW-2:0], 1'b0};
            end
          end
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == IW'(1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_ch.valid <= 1'b1;
            if (out_cnt_r + 1'b1 >= total) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              in_cnt_r  <= '0;
              wptr_r    <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
              out_cnt_r <= '0;
              optr_r    <= '0;
            end else begin
              out_cnt_r <= out_cnt_r + 1'b1;
              optr_r    <= (optr_r == LAST_ADDR) ? '0 : optr_r + 1'b1;
              if (out_col_r + 1'b1 >= w_eff) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + 1'b1;
              end else begin
                out_col_r <= out_col_r + 1'b1;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // a register write restarts the frame
      if (cfg_acc) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        in_cnt_r  <= '0;
        wptr_r    <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        out_cnt_r <= '0;
        optr_r    <= '0;
      end
    end
  end

  // clear before the walk, then accumulate the word read in the cycle before
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      cnt_r <= '0;
      for (int k = 0; k < 4; k++) sum_r[k] <= '0;
    end else if (rd_en_r) begin
      cnt_r <= cnt_r + 1'b1;
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= sum_r[k] + SW'(rd_data_r[8*k +: 8]);
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.mean_a        <= quo_r[0][7:0];
      out_ch.mean_b        <= (ch_eff > CHAN_W'(1)) ? quo_r[1][7:0] : '0;
      out_ch.mean_c        <= (ch_eff > CHAN_W'(2)) ? quo_r[2][7:0] : '0;
      out_ch.mean_d        <= (ch_eff > CHAN_W'(3)) ? quo_r[3][7:0] : '0;
      out_ch.last_of_frame <= (out_cnt_r + 1'b1 == total);
    end
  end

endmodule

// File: rtl/bfe_checker.sv
// ----------------------------------------------------------------------------
// bfe_checker
// Port-level checks of the box filter, bound to the top level.
// ----------------------------------------------------------------------------
module bfe_checker
  import bfe_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_mean_a,
  input logic    out_last
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mean_a) && $stable(out_last))
    else $error("stalled result changed");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // in the cycle after an accepted word the block is busy and takes no word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken on consecutive cycles");

endmodule

bind box_filter_edge_normalized bfe_checker u_bfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_mean_a (out_ch.mean_a),
  .out_last   (out_ch.last_of_frame)
);
